// ===== rtl/core/emarat_pkg.sv =====
// Shared constants, codes and control bundles of the adaptive threshold unit.
`timescale 1ns / 1ps
package emarat_pkg;

  // Default sizes handed to the top level
  localparam int TIME_BITS_DEFAULT          = 40;
  localparam int THRESHOLD_BITS_DEFAULT     = 11;
  localparam int RATE_FRACTION_BITS_DEFAULT = 31;

  // Fixed field widths
  localparam int OP_BITS        = 2;
  localparam int COUNT_BITS     = 8;
  localparam int EMA_BITS       = 32;
  localparam int ALPHA_BITS     = 17;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int MIX_SHIFT      = 16;

  // Alpha of one in Q1.16 and the half-LSB used for rounding the mix
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [15:0]           MIX_ROUND = 16'h8000;

  // Event opcodes
  localparam logic [OP_BITS-1:0] OP_SENSOR = 2'd0;
  localparam logic [OP_BITS-1:0] OP_TIMER  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RESET  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EMA_ALPHA         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_TARGET       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_INITIAL = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_MIN     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_MAX     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEVIATIONS_NEEDED = 3'd5;

  // Register values after reset
  localparam logic [ALPHA_BITS-1:0] EMA_ALPHA_RESET         = 17'd6554;
  localparam logic [EMA_BITS-1:0]   RATE_TARGET_RESET       = 32'd596523;
  localparam logic [15:0]           THRESHOLD_INITIAL_RESET = 16'd250;
  localparam logic [15:0]           THRESHOLD_MIN_RESET     = 16'd50;
  localparam logic [15:0]           THRESHOLD_MAX_RESET     = 16'd2000;
  localparam logic [COUNT_BITS-1:0] DEVIATIONS_NEEDED_RESET = 8'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;        // latch the incoming event
    logic div_rate_load;  // start 2^F / dt
    logic div_th_load;    // start threshold*ema / target
    logic div_step;       // one restoring divide step
    logic quot_clear;     // rate of zero for a long gap
    logic mul_new;        // alpha * rate
    logic mul_old;        // (1 - alpha) * ema
    logic mix;            // fold both products into the ema
    logic clamp;          // saturate and clamp the new threshold
    logic commit;         // update state and load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_BITS-1:0] opcode;
    logic               adapt_ok;  // primed and a previous wake time exists
    logic               dt_pos;    // now is later than the last wake
    logic               dt_big;    // gap longer than 2^F seconds
  } stat_t;

endpackage

// ===== rtl/core/emarat_evt_if.sv =====
// Event channel: opcode, time stamp and baseline flag.
`timescale 1ns / 1ps
interface emarat_evt_if #(
  parameter int TIME_BITS = emarat_pkg::TIME_BITS_DEFAULT
) ();
  logic                               valid;
  logic                               ready;
  logic [emarat_pkg::OP_BITS-1:0]     opcode;
  logic [TIME_BITS-1:0]               now_seconds;
  logic                               baseline_wake;

  modport source (output valid, opcode, now_seconds, baseline_wake, input ready);
  modport sink   (input valid, opcode, now_seconds, baseline_wake, output ready);
endinterface

// ===== rtl/core/emarat_res_if.sv =====
// Result channel: threshold, alarm, deviation count and rate estimate.
`timescale 1ns / 1ps
interface emarat_res_if #(
  parameter int THRESHOLD_BITS = emarat_pkg::THRESHOLD_BITS_DEFAULT
) ();
  logic                                valid;
  logic                                ready;
  logic [THRESHOLD_BITS-1:0]           act_threshold;
  logic                                alarm;
  logic [emarat_pkg::COUNT_BITS-1:0]   deviation_count;
  logic [emarat_pkg::EMA_BITS-1:0]     rate_estimate;

  modport source (output valid, act_threshold, alarm, deviation_count, rate_estimate,
                  input ready);
  modport sink   (input valid, act_threshold, alarm, deviation_count, rate_estimate,
                  output ready);
endinterface

// ===== rtl/core/emarat_cfg_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface emarat_cfg_if ();
  logic                                    valid;
  logic                                    ready;
  logic [emarat_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [emarat_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/emarat_regs.sv =====
// Configuration register file of the adaptive threshold unit.
`timescale 1ns / 1ps
module emarat_regs #(
  parameter int THRESHOLD_BITS = emarat_pkg::THRESHOLD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  emarat_cfg_if.sink                          cfg,
  output logic [emarat_pkg::ALPHA_BITS-1:0]   ema_alpha,
  output logic [emarat_pkg::EMA_BITS-1:0]     rate_target,
  output logic [THRESHOLD_BITS-1:0]           threshold_initial,
  output logic [THRESHOLD_BITS-1:0]           threshold_min,
  output logic [THRESHOLD_BITS-1:0]           threshold_max,
  output logic [emarat_pkg::COUNT_BITS-1:0]   deviations_needed
);

  // Writes are taken whenever valid, so the channel never stalls
  assign cfg.ready = 1'b1;

  // Decode the index and take the low bits of the write data
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_alpha         <= emarat_pkg::EMA_ALPHA_RESET;
      rate_target       <= emarat_pkg::RATE_TARGET_RESET;
      threshold_initial <= emarat_pkg::THRESHOLD_INITIAL_RESET[THRESHOLD_BITS-1:0];
      threshold_min     <= emarat_pkg::THRESHOLD_MIN_RESET[THRESHOLD_BITS-1:0];
      threshold_max     <= emarat_pkg::THRESHOLD_MAX_RESET[THRESHOLD_BITS-1:0];
      deviations_needed <= emarat_pkg::DEVIATIONS_NEEDED_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        emarat_pkg::CFG_EMA_ALPHA: begin
          ema_alpha <= cfg.data[emarat_pkg::ALPHA_BITS-1:0];
        end
        emarat_pkg::CFG_RATE_TARGET: begin
          rate_target <= cfg.data[emarat_pkg::EMA_BITS-1:0];
        end
        emarat_pkg::CFG_THRESHOLD_INITIAL: begin
          threshold_initial <= cfg.data[THRESHOLD_BITS-1:0];
        end
        emarat_pkg::CFG_THRESHOLD_MIN: begin
          threshold_min <= cfg.data[THRESHOLD_BITS-1:0];
        end
        emarat_pkg::CFG_THRESHOLD_MAX: begin
          threshold_max <= cfg.data[THRESHOLD_BITS-1:0];
        end
        emarat_pkg::CFG_DEVIATIONS_NEEDED: begin
          deviations_needed <= cfg.data[emarat_pkg::COUNT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/emarat_ctrl.sv =====
// Controller state machine: sequences the divider, multiplier and commit.
`timescale 1ns / 1ps
module emarat_ctrl #(
  parameter int THRESHOLD_BITS     = emarat_pkg::THRESHOLD_BITS_DEFAULT,
  parameter int RATE_FRACTION_BITS = emarat_pkg::RATE_FRACTION_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              evt_valid,
  output logic              evt_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output emarat_pkg::cmd_t  cmd,
  input  emarat_pkg::stat_t stat
);

  localparam int PROD_W = THRESHOLD_BITS + emarat_pkg::EMA_BITS;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam logic [CNT_W-1:0] RATE_STEPS = CNT_W'(RATE_FRACTION_BITS + 1);
  localparam logic [CNT_W-1:0] TH_STEPS   = CNT_W'(PROD_W);
  localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECIDE   = 10'b00_0000_0010,
    S_DIV_RATE = 10'b00_0000_0100,
    S_MUL_NEW  = 10'b00_0000_1000,
    S_MUL_OLD  = 10'b00_0001_0000,
    S_MIX      = 10'b00_0010_0000,
    S_MUL_TH   = 10'b00_0100_0000,
    S_DIV_TH   = 10'b00_1000_0000,
    S_CLAMP    = 10'b01_0000_0000,
    S_COMMIT   = 10'b10_0000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] step_cnt_next;
  logic             out_free;

  // Result slot is free when empty or being drained this cycle
  assign out_free  = !res_valid || res_ready;
  assign evt_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (evt_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if ((stat.opcode inside {emarat_pkg::OP_SENSOR, emarat_pkg::OP_TIMER}) &&
            stat.adapt_ok && stat.dt_pos) begin
          if (stat.dt_big) begin
            cmd.quot_clear = 1'b1;
            state_next     = S_MUL_NEW;
          end else begin
            cmd.div_rate_load = 1'b1;
            step_cnt_next     = RATE_STEPS;
            state_next        = S_DIV_RATE;
          end
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIV_RATE: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt - LAST_STEP;
        if (step_cnt == LAST_STEP) begin
          state_next = S_MUL_NEW;
        end
      end
      S_MUL_NEW: begin
        cmd.mul_new = 1'b1;
        state_next  = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        cmd.mul_old = 1'b1;
        state_next  = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_MUL_TH;
      end
      S_MUL_TH: begin
        cmd.div_th_load = 1'b1;
        step_cnt_next   = TH_STEPS;
        state_next      = S_DIV_TH;
      end
      S_DIV_TH: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt - LAST_STEP;
        if (step_cnt == LAST_STEP) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold until the result register can take the beat
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/emarat_dpath.sv =====
// Datapath: event state, shared multiplier, restoring divider, result register.
`timescale 1ns / 1ps
module emarat_dpath #(
  parameter int TIME_BITS          = emarat_pkg::TIME_BITS_DEFAULT,
  parameter int THRESHOLD_BITS     = emarat_pkg::THRESHOLD_BITS_DEFAULT,
  parameter int RATE_FRACTION_BITS = emarat_pkg::RATE_FRACTION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  emarat_pkg::cmd_t                    cmd,
  output emarat_pkg::stat_t                   stat,
  input  logic [emarat_pkg::OP_BITS-1:0]      opcode,
  input  logic [TIME_BITS-1:0]                now_seconds,
  input  logic                                baseline_wake,
  input  logic [emarat_pkg::ALPHA_BITS-1:0]   ema_alpha,
  input  logic [emarat_pkg::EMA_BITS-1:0]     rate_target,
  input  logic [THRESHOLD_BITS-1:0]           threshold_initial,
  input  logic [THRESHOLD_BITS-1:0]           threshold_min,
  input  logic [THRESHOLD_BITS-1:0]           threshold_max,
  input  logic [emarat_pkg::COUNT_BITS-1:0]   deviations_needed,
  output logic [THRESHOLD_BITS-1:0]           act_threshold,
  output logic                                alarm,
  output logic [emarat_pkg::COUNT_BITS-1:0]   deviation_count,
  output logic [emarat_pkg::EMA_BITS-1:0]     rate_estimate
);

  localparam int EW     = emarat_pkg::EMA_BITS;
  localparam int AW     = emarat_pkg::ALPHA_BITS;
  localparam int CW     = emarat_pkg::COUNT_BITS;
  localparam int PROD_W = THRESHOLD_BITS + EW;
  localparam int MUL_W  = AW + EW;
  localparam logic [TIME_BITS-1:0] DT_LIMIT = TIME_BITS'(1) << RATE_FRACTION_BITS;
  localparam logic [PROD_W-1:0]    DVD_RATE = PROD_W'(1) << (PROD_W - 1);
  localparam logic [CW-1:0]        CNT_ONE  = CW'(1);

  // Latched event
  logic [emarat_pkg::OP_BITS-1:0] op_r;
  logic [TIME_BITS-1:0]           now_r;
  logic                           base_r;

  // Persistent state
  logic                      primed;
  logic [TIME_BITS-1:0]      last_time;
  logic [EW-1:0]             ema;
  logic [THRESHOLD_BITS-1:0] cur_th;
  logic [CW-1:0]             dev_cnt;

  // Products and divider
  logic [MUL_W-1:0]  acc_new;
  logic [MUL_W-1:0]  acc_old;
  logic [PROD_W-1:0] dvd;
  logic [PROD_W-1:0] quot;
  logic [EW-1:0]     rem;
  logic [EW-1:0]     dsr;

  // Combinational values
  logic [TIME_BITS-1:0]      dt;
  logic [AW-1:0]             alpha_sat;
  logic [AW-1:0]             alpha_rest;
  logic [AW-1:0]             mul_a;
  logic [EW-1:0]             mul_b;
  logic [MUL_W-1:0]          mul_p;
  logic [MUL_W:0]            mix_sum;
  logic [EW-1:0]             target_div;
  logic [EW:0]               rem_sh;
  logic [EW+1:0]             diff;
  logic                      q_bit;
  logic [THRESHOLD_BITS-1:0] q_sat;
  logic [THRESHOLD_BITS-1:0] t_lo;
  logic [THRESHOLD_BITS-1:0] t_clamp;
  logic [CW-1:0]             cnt_inc;

  // Commit values
  logic                      primed_next;
  logic [TIME_BITS-1:0]      last_time_next;
  logic [EW-1:0]             ema_next;
  logic [THRESHOLD_BITS-1:0] cur_th_next;
  logic [CW-1:0]             dev_cnt_next;
  logic                      alarm_next;

  // Status for the controller
  assign dt              = now_r - last_time;
  assign stat.opcode     = op_r;
  assign stat.adapt_ok   = primed && (last_time != '0);
  assign stat.dt_pos     = now_r > last_time;
  assign stat.dt_big     = dt > DT_LIMIT;

  // Alpha above one acts as one
  assign alpha_sat  = ema_alpha[AW-1] ? emarat_pkg::ALPHA_ONE : ema_alpha;
  assign alpha_rest = emarat_pkg::ALPHA_ONE - alpha_sat;

  // Shared multiplier: alpha*rate, (1-alpha)*ema, threshold*ema
  always_comb begin
    if (cmd.mul_new) begin
      mul_a = alpha_sat;
      mul_b = quot[EW-1:0];
    end else if (cmd.mul_old) begin
      mul_a = alpha_rest;
      mul_b = ema;
    end else begin
      mul_a = AW'(cur_th);
      mul_b = ema;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Round half up and keep 32 bits of the mix
  assign mix_sum = {1'b0, acc_new} + {1'b0, acc_old} + (MUL_W + 1)'(emarat_pkg::MIX_ROUND);

  // A zero target divides as one
  assign target_div = (rate_target == '0) ? EW'(1) : rate_target;

  // One restoring divide step
  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};
  assign q_bit  = ~diff[EW+1];

  // Saturate, raise to min, then lower to max
  assign q_sat   = (quot[PROD_W-1:THRESHOLD_BITS] != '0) ? '1 : quot[THRESHOLD_BITS-1:0];
  assign t_lo    = (q_sat < threshold_min) ? threshold_min : q_sat;
  assign t_clamp = (t_lo > threshold_max) ? threshold_max : t_lo;

  // Per-op state update at commit
  assign cnt_inc = dev_cnt + CNT_ONE;
  always_comb begin
    primed_next    = primed;
    last_time_next = last_time;
    ema_next       = ema;
    cur_th_next    = cur_th;
    dev_cnt_next   = dev_cnt;
    alarm_next     = 1'b0;
    case (op_r)
      emarat_pkg::OP_SENSOR: begin
        primed_next    = 1'b1;
        last_time_next = now_r;
        if (base_r) begin
          dev_cnt_next = '0;
        end else if (cnt_inc >= deviations_needed) begin
          alarm_next   = 1'b1;
          dev_cnt_next = '0;
        end else begin
          dev_cnt_next = cnt_inc;
        end
      end
      emarat_pkg::OP_TIMER: begin
        primed_next = 1'b1;
      end
      emarat_pkg::OP_RESET: begin
        primed_next    = 1'b0;
        last_time_next = '0;
        ema_next       = rate_target;
        cur_th_next    = threshold_initial;
        dev_cnt_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // Persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      last_time <= '0;
      ema       <= emarat_pkg::RATE_TARGET_RESET;
      cur_th    <= emarat_pkg::THRESHOLD_INITIAL_RESET[THRESHOLD_BITS-1:0];
      dev_cnt   <= '0;
    end else if (cmd.commit) begin
      primed    <= primed_next;
      last_time <= last_time_next;
      ema       <= ema_next;
      cur_th    <= cur_th_next;
      dev_cnt   <= dev_cnt_next;
    end else begin
      if (cmd.mix) begin
        ema <= mix_sum[emarat_pkg::MIX_SHIFT +: EW];
      end
      if (cmd.clamp) begin
        cur_th <= t_clamp;
      end
    end
  end

  // Event latch and products
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode;
      now_r  <= now_seconds;
      base_r <= baseline_wake;
    end
    if (cmd.mul_new) begin
      acc_new <= mul_p;
    end
    if (cmd.mul_old) begin
      acc_old <= mul_p;
    end
  end

  // Divider: load, clear or shift one quotient bit in
  always_ff @(posedge clk) begin
    if (cmd.div_rate_load) begin
      dvd  <= DVD_RATE;
      rem  <= '0;
      quot <= '0;
      dsr  <= dt[EW-1:0];
    end else if (cmd.div_th_load) begin
      dvd  <= mul_p[PROD_W-1:0];
      rem  <= '0;
      quot <= '0;
      dsr  <= target_div;
    end else if (cmd.quot_clear) begin
      quot <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[PROD_W-2:0], 1'b0};
      rem  <= q_bit ? diff[EW-1:0] : rem_sh[EW-1:0];
      quot <= {quot[PROD_W-2:0], q_bit};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      act_threshold   <= cur_th_next;
      alarm           <= alarm_next;
      deviation_count <= dev_cnt_next;
      rate_estimate   <= ema_next;
    end
  end

endmodule

// ===== rtl/core/ema_rate_adaptive_threshold_unit.sv =====
// Top level of the EMA wake-rate adaptive activity threshold unit.
`timescale 1ns / 1ps
// Takes one event beat at a time and returns one result beat per event. A sensor
// or timer wake that adapts runs two divides, one quotient bit per cycle through
// a single shared restoring divider. Wakes that only prime or record time, resets
// and unused opcodes go straight to the commit; a gap longer than
// 2^RATE_FRACTION_BITS seconds skips the first divide. One result register
// buffers the output, so a new event is taken while the previous result waits.
// Configuration writes must be made while idle.
module ema_rate_adaptive_threshold_unit #(
  parameter int TIME_BITS          = emarat_pkg::TIME_BITS_DEFAULT,
  parameter int THRESHOLD_BITS     = emarat_pkg::THRESHOLD_BITS_DEFAULT,
  parameter int RATE_FRACTION_BITS = emarat_pkg::RATE_FRACTION_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  emarat_evt_if.sink evt,
  emarat_res_if.source res,
  emarat_cfg_if.sink cfg
);

  emarat_pkg::cmd_t  cmd;
  emarat_pkg::stat_t stat;

  logic [emarat_pkg::ALPHA_BITS-1:0] ema_alpha;
  logic [emarat_pkg::EMA_BITS-1:0]   rate_target;
  logic [THRESHOLD_BITS-1:0]         threshold_initial;
  logic [THRESHOLD_BITS-1:0]         threshold_min;
  logic [THRESHOLD_BITS-1:0]         threshold_max;
  logic [emarat_pkg::COUNT_BITS-1:0] deviations_needed;

  // Configuration registers
  emarat_regs #(
    .THRESHOLD_BITS (THRESHOLD_BITS)
  ) u_regs (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .ema_alpha         (ema_alpha),
    .rate_target       (rate_target),
    .threshold_initial (threshold_initial),
    .threshold_min     (threshold_min),
    .threshold_max     (threshold_max),
    .deviations_needed (deviations_needed)
  );

  // Sequencer
  emarat_ctrl #(
    .THRESHOLD_BITS     (THRESHOLD_BITS),
    .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and state
  emarat_dpath #(
    .TIME_BITS          (TIME_BITS),
    .THRESHOLD_BITS     (THRESHOLD_BITS),
    .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .opcode            (evt.opcode),
    .now_seconds       (evt.now_seconds),
    .baseline_wake     (evt.baseline_wake),
    .ema_alpha         (ema_alpha),
    .rate_target       (rate_target),
    .threshold_initial (threshold_initial),
    .threshold_min     (threshold_min),
    .threshold_max     (threshold_max),
    .deviations_needed (deviations_needed),
    .act_threshold     (res.act_threshold),
    .alarm             (res.alarm),
    .deviation_count   (res.deviation_count),
    .rate_estimate     (res.rate_estimate)
  );

endmodule
